@@ rtl/dlrd_pkg.sv @@
// Shared types and constants for the delimiter run deframer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package dlrd_pkg;

	localparam int BYTE_W     = 8;
	localparam int CNT_W      = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_END_BYTE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RUN_LENGTH = 2'd2;

	// Input function codes.
	localparam logic FUNC_BYTE    = 1'b0;
	localparam logic FUNC_RELEASE = 1'b1;

	// Saturation limit of the end run counter.
	localparam logic [CNT_W-1:0] END_COUNT_MAX = 4'd15;

	typedef struct packed {
		logic              captured;
		logic [BYTE_W-1:0] position;
		logic [BYTE_W-1:0] data_byte;
		logic              frame_complete;
		logic [BYTE_W-1:0] frame_length;
		logic [BYTE_W-1:0] body_length;
		logic              too_short;
	} result_t;

endpackage

`default_nettype wire

@@ rtl/dlrd_core.sv @@
// Deframer state: configuration registers, delimiter counters, write index and lock.
// Computes one result per request from the current state; depends on dlrd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dlrd_core
	import dlrd_pkg::*;
#(
	parameter int BUFFER_DEPTH = 256,
	parameter int MAX_RUN      = 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_write,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  accept,
	input  wire logic                  func,
	input  wire logic [BYTE_W-1:0]     data_in,
	output result_t                    result
);

	localparam int IDX_W = $clog2(BUFFER_DEPTH);
	localparam logic [IDX_W-1:0] LastIdx = IDX_W'(BUFFER_DEPTH - 1);
	localparam logic [CNT_W-1:0] MaxRun  = CNT_W'(MAX_RUN);

	logic [BYTE_W-1:0] start_byte_q;
	logic [BYTE_W-1:0] end_byte_q;
	logic [CNT_W-1:0]  run_length_q;

	logic [CNT_W-1:0]  start_count_q;
	logic [CNT_W-1:0]  end_count_q;
	logic [IDX_W-1:0]  write_index_q;
	logic              locked_q;

	logic [CNT_W-1:0]  run;
	logic [CNT_W-1:0]  start_count_d;
	logic [CNT_W-1:0]  end_count_d;
	logic [IDX_W-1:0]  write_index_d;
	logic              locked_d;
	logic              capture;
	logic [BYTE_W-1:0] flen;
	logic [BYTE_W-1:0] run_plus_crc;

	always_comb begin
		if (run_length_q == '0) begin
			run = CNT_W'(1);
		end else if (run_length_q > MaxRun) begin
			run = MaxRun;
		end else begin
			run = run_length_q;
		end
	end

	assign capture      = (func == FUNC_BYTE) && !locked_q && (start_count_q >= run);
	assign run_plus_crc = BYTE_W'(run) + BYTE_W'(2);

	always_comb begin
		start_count_d = start_count_q;
		end_count_d   = end_count_q;
		write_index_d = write_index_q;
		locked_d      = locked_q;
		result        = '0;
		flen          = '0;

		if (func == FUNC_RELEASE) begin
			start_count_d = '0;
			end_count_d   = '0;
			write_index_d = '0;
			locked_d      = 1'b0;
		end else begin
			if (capture) begin
				result.captured  = 1'b1;
				result.position  = BYTE_W'(write_index_q);
				result.data_byte = data_in;
				if (data_in == end_byte_q) begin
					if (end_count_q < END_COUNT_MAX) begin
						end_count_d = end_count_q + CNT_W'(1);
					end
				end else begin
					end_count_d = '0;
				end
				write_index_d = (write_index_q == LastIdx) ? '0 : write_index_q + IDX_W'(1);
				if (end_count_d == run) begin
					locked_d              = 1'b1;
					flen                  = BYTE_W'(write_index_d);
					result.frame_complete = 1'b1;
					result.frame_length   = flen;
					if (flen < run_plus_crc) begin
						result.too_short = 1'b1;
					end else begin
						result.body_length = flen - run_plus_crc;
					end
				end
			end
			// The start counter runs on every received byte, even while capturing.
			if (data_in == start_byte_q) begin
				if (start_count_q < run) begin
					start_count_d = start_count_q + CNT_W'(1);
				end
			end else if (start_count_q < run) begin
				start_count_d = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q  <= '0;
			end_byte_q    <= '0;
			run_length_q  <= CNT_W'(3);
			start_count_q <= '0;
			end_count_q   <= '0;
			write_index_q <= '0;
			locked_q      <= 1'b0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					CFG_START_BYTE: start_byte_q <= cfg_data;
					CFG_END_BYTE:   end_byte_q   <= cfg_data;
					CFG_RUN_LENGTH: run_length_q <= cfg_data[CNT_W-1:0];
					default: ;
				endcase
			end
			if (accept) begin
				start_count_q <= start_count_d;
				end_count_q   <= end_count_d;
				write_index_q <= write_index_d;
				locked_q      <= locked_d;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/dlrd_outbuf.sv @@
// Result register with a skid stage, so a new request is taken while a result waits.
// Depends on dlrd_pkg for the result type.
`timescale 1ns / 1ps
`default_nettype none

module dlrd_outbuf
	import dlrd_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  wire result_t push_data,
	output logic         full,
	output logic         out_valid,
	input  wire logic    out_stall,
	output result_t      out_data
);

	logic    out_valid_q;
	result_t out_data_q;
	logic    skid_valid_q;
	result_t skid_data_q;
	logic    pop;

	assign pop       = out_valid_q && !out_stall;
	assign full      = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (skid_valid_q) begin
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= push;
				end
			end else if (push) begin
				if (!out_valid_q) begin
					out_valid_q <= 1'b1;
				end else begin
					skid_valid_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && skid_valid_q) begin
			out_data_q <= skid_data_q;
		end else if (push && (pop || !out_valid_q)) begin
			out_data_q <= push_data;
		end
		if (push && out_valid_q && !pop) begin
			skid_data_q <= push_data;
		end
	end

endmodule

`default_nettype wire

@@ rtl/delimiter_run_deframer.sv @@
// Top level of the delimiter run deframer: request handshake, core state and result buffer.
// Depends on dlrd_pkg, dlrd_core and dlrd_outbuf.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+------------------------------------------
//   input    | in        | in_valid / in_stall  | func, data_in
//   result   | out       | out_valid / out_stall| captured, position, data_byte,
//            |           |                      | frame_complete, frame_length, body_length,
//            |           |                      | too_short
//   config   | in        | cfg_write            | cfg_index, cfg_data
//
// One request per clock while in_stall is low; its result is computed combinationally from
// the counter state beside the compare-and-count update of the counters, and then registered.
// Reset clears the counters, write index, lock and buffer; registers return to 0, 0 and 3.
// A two-entry result buffer keeps taking requests while one result is stalled; in_stall
// rises only when both entries hold results.
`timescale 1ns / 1ps
`default_nettype none

module delimiter_run_deframer
	import dlrd_pkg::*;
#(
	parameter int BUFFER_DEPTH = 256,
	parameter int MAX_RUN      = 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_write,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic                  func,
	input  wire logic [BYTE_W-1:0]     data_in,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic                       captured,
	output logic [BYTE_W-1:0]          position,
	output logic [BYTE_W-1:0]          data_byte,
	output logic                       frame_complete,
	output logic [BYTE_W-1:0]          frame_length,
	output logic [BYTE_W-1:0]          body_length,
	output logic                       too_short
);

	logic    accept;
	logic    full;
	result_t result;
	result_t out_data;

	assign in_stall = full;
	assign accept   = in_valid && !full;

	dlrd_core #(
		.BUFFER_DEPTH(BUFFER_DEPTH),
		.MAX_RUN     (MAX_RUN)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.accept   (accept),
		.func     (func),
		.data_in  (data_in),
		.result   (result)
	);

	dlrd_outbuf u_outbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.push_data(result),
		.full     (full),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

	assign captured       = out_data.captured;
	assign position       = out_data.position;
	assign data_byte      = out_data.data_byte;
	assign frame_complete = out_data.frame_complete;
	assign frame_length   = out_data.frame_length;
	assign body_length    = out_data.body_length;
	assign too_short      = out_data.too_short;

endmodule

`default_nettype wire

@@ tb/sv/deframer_checker.sv @@
// Checker for the delimiter run deframer: watches the register port and both channels,
// predicts each result from its own copy of the state and compares it. Depends on dlrd_pkg.
`timescale 1ns / 1ps

module deframer_checker
	import dlrd_pkg::*;
#(
	parameter int BUFFER_DEPTH = 256,
	parameter int MAX_RUN      = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  logic                  func,
	input  logic [BYTE_W-1:0]     data_in,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  logic                  captured,
	input  logic [BYTE_W-1:0]     position,
	input  logic [BYTE_W-1:0]     data_byte,
	input  logic                  frame_complete,
	input  logic [BYTE_W-1:0]     frame_length,
	input  logic [BYTE_W-1:0]     body_length,
	input  logic                  too_short,
	output int                    mismatch_count,
	output int                    pending_count,
	output int                    results_seen,
	output int                    frames_done,
	output int                    short_frames
);

	logic [BYTE_W-1:0] start_val;
	logic [BYTE_W-1:0] end_val;
	logic [CNT_W-1:0]  run_val;

	logic [CNT_W-1:0]  start_cnt;
	logic [CNT_W-1:0]  end_cnt;
	logic [BYTE_W-1:0] wr_pos;
	logic              lock;

	result_t deframe_results_q[$];
	result_t seen;
	result_t want;
	result_t fresh;

	function automatic int unsigned clamp_run(input logic [CNT_W-1:0] raw);
		if (raw == 0)
			return 1;
		if (raw > MAX_RUN)
			return MAX_RUN;
		return int'(raw);
	endfunction

	task automatic deframe_step(input logic op, input logic [BYTE_W-1:0] b, output result_t r);
		int unsigned run;
		int unsigned flen;
		r = '0;
		run = clamp_run(run_val);
		if (op == FUNC_RELEASE) begin
			start_cnt = '0;
			end_cnt = '0;
			wr_pos = '0;
			lock = 1'b0;
		end else begin
			// Capture looks at the start count as it stood before this byte.
			if (!lock && start_cnt >= run) begin
				r.captured = 1'b1;
				r.position = wr_pos;
				r.data_byte = b;
				if (b == end_val) begin
					if (end_cnt < END_COUNT_MAX)
						end_cnt = end_cnt + 1'b1;
				end else begin
					end_cnt = '0;
				end
				wr_pos = BYTE_W'((int'(wr_pos) + 1) % BUFFER_DEPTH);
				if (end_cnt == run) begin
					lock = 1'b1;
					flen = int'(wr_pos);
					r.frame_complete = 1'b1;
					r.frame_length = wr_pos;
					if (flen < run + 2)
						r.too_short = 1'b1;
					else
						r.body_length = BYTE_W'(flen - run - 2);
				end
			end
			// Once the start run is reached, other bytes no longer clear it.
			if (b == start_val) begin
				if (start_cnt < run)
					start_cnt = start_cnt + 1'b1;
			end else if (start_cnt < run) begin
				start_cnt = '0;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_val = '0;
			end_val = '0;
			run_val = CNT_W'(3);
			start_cnt = '0;
			end_cnt = '0;
			wr_pos = '0;
			lock = 1'b0;
			deframe_results_q.delete();
			mismatch_count <= 0;
			pending_count <= 0;
			results_seen <= 0;
			frames_done <= 0;
			short_frames <= 0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					CFG_START_BYTE: start_val = cfg_data;
					CFG_END_BYTE:   end_val = cfg_data;
					CFG_RUN_LENGTH: run_val = cfg_data[CNT_W-1:0];
					default: ;
				endcase
			end
			// The result leaving now belongs to an older request, so pop before pushing.
			if (out_valid && !out_stall) begin
				seen = '{captured, position, data_byte, frame_complete, frame_length,
					body_length, too_short};
				results_seen <= results_seen + 1;
				if (deframe_results_q.size() == 0) begin
					if (mismatch_count < 10) begin
						$write("%0t: result with nothing pending: cap=%0d pos=%0d",
							$realtime, seen.captured, seen.position);
						$display(" dat=%02h done=%0d flen=%0d blen=%0d short=%0d",
							seen.data_byte, seen.frame_complete, seen.frame_length,
							seen.body_length, seen.too_short);
					end
					mismatch_count <= mismatch_count + 1;
				end else begin
					want = deframe_results_q.pop_front();
					if (want.frame_complete) begin
						frames_done <= frames_done + 1;
						if (want.too_short)
							short_frames <= short_frames + 1;
					end
					if (seen.captured !== want.captured || seen.position !== want.position ||
						seen.data_byte !== want.data_byte ||
						seen.frame_complete !== want.frame_complete ||
						seen.frame_length !== want.frame_length ||
						seen.body_length !== want.body_length ||
						seen.too_short !== want.too_short) begin
						if (mismatch_count < 10) begin
							$display("%0t: result differs", $realtime);
							$write("  expected cap=%0d pos=%0d dat=%02h done=%0d",
								want.captured, want.position, want.data_byte,
								want.frame_complete);
							$display(" flen=%0d blen=%0d short=%0d",
								want.frame_length, want.body_length, want.too_short);
							$write("  actual   cap=%0d pos=%0d dat=%02h done=%0d",
								seen.captured, seen.position, seen.data_byte,
								seen.frame_complete);
							$display(" flen=%0d blen=%0d short=%0d",
								seen.frame_length, seen.body_length, seen.too_short);
						end
						mismatch_count <= mismatch_count + 1;
					end
				end
			end
			if (in_valid && !in_stall) begin
				deframe_step(func, data_in, fresh);
				deframe_results_q.push_back(fresh);
			end
			pending_count <= deframe_results_q.size();
		end
	end

endmodule

@@ tb/sv/tb_delimiter_run_deframer.sv @@
// Testbench top for the delimiter run deframer: clock, reset, register writes, frame
// requests and random stalls. Depends on dlrd_pkg, delimiter_run_deframer and deframer_checker.
`timescale 1ns / 1ps

module tb_delimiter_run_deframer;
	import dlrd_pkg::*;

	localparam int BUFFER_DEPTH = 256;
	localparam int MAX_RUN      = 8;
	localparam int PHASES       = 6;
	localparam int PHASE_ITEMS  = 160;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_START_BYTE;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic                  func = FUNC_BYTE;
	logic [BYTE_W-1:0]     data_in = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  captured;
	logic [BYTE_W-1:0]     position;
	logic [BYTE_W-1:0]     data_byte;
	logic                  frame_complete;
	logic [BYTE_W-1:0]     frame_length;
	logic [BYTE_W-1:0]     body_length;
	logic                  too_short;

	int mismatch_count;
	int pending_count;
	int results_seen;
	int frames_done;
	int short_frames;

	bit          idle_on = 1'b1;
	bit          hold_done = 1'b0;
	int          requests_sent = 0;
	int          stall_cycles = 0;
	logic [7:0]  cur_start = 8'h00;
	logic [7:0]  cur_end = 8'h00;
	int unsigned cur_run = 3;

	always #5 clk = ~clk;

	delimiter_run_deframer #(
		.BUFFER_DEPTH(BUFFER_DEPTH),
		.MAX_RUN(MAX_RUN)
	) u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .func(func), .data_in(data_in),
		.out_valid(out_valid), .out_stall(out_stall),
		.captured(captured), .position(position), .data_byte(data_byte),
		.frame_complete(frame_complete), .frame_length(frame_length),
		.body_length(body_length), .too_short(too_short)
	);

	deframer_checker #(
		.BUFFER_DEPTH(BUFFER_DEPTH),
		.MAX_RUN(MAX_RUN)
	) u_check (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .func(func), .data_in(data_in),
		.out_valid(out_valid), .out_stall(out_stall),
		.captured(captured), .position(position), .data_byte(data_byte),
		.frame_complete(frame_complete), .frame_length(frame_length),
		.body_length(body_length), .too_short(too_short),
		.mismatch_count(mismatch_count), .pending_count(pending_count),
		.results_seen(results_seen), .frames_done(frames_done),
		.short_frames(short_frames)
	);

	// Offers one request and returns at the edge where it is taken.
	task automatic send_item(input logic op, input logic [7:0] b);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= op;
		data_in <= b;
		@(posedge clk);
		while (in_stall) begin
			stall_cycles++;
			@(posedge clk);
		end
		requests_sent++;
	endtask

	task automatic drain_results(input int settle);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_regs(input logic [7:0] s, input logic [7:0] e,
		input logic [7:0] rraw);
		cfg_write <= 1'b1;
		cfg_index <= CFG_START_BYTE;
		cfg_data <= s;
		@(posedge clk);
		cfg_index <= CFG_END_BYTE;
		cfg_data <= e;
		@(posedge clk);
		cfg_index <= CFG_RUN_LENGTH;
		cfg_data <= rraw;
		@(posedge clk);
		cfg_write <= 1'b0;
		cur_start = s;
		cur_end = e;
		if (rraw[3:0] == 0)
			cur_run = 1;
		else if (rraw[3:0] > MAX_RUN)
			cur_run = MAX_RUN;
		else
			cur_run = int'(rraw[3:0]);
	endtask

	function automatic logic [7:0] pick_other(input logic [7:0] avoid);
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		if (b == avoid)
			b = b + 8'd1;
		return b;
	endfunction

	// A clean frame has no noise in front and no end byte in its body, so its length is exact.
	task automatic send_frame(input int body, input bit clean);
		int         k;
		logic [7:0] b;
		if (!clean) begin
			repeat ($urandom_range(0, 3)) send_item(FUNC_BYTE, 8'($urandom_range(0, 255)));
			if ($urandom_range(0, 4) == 0) begin
				repeat (cur_run - 1) send_item(FUNC_BYTE, cur_start);
				send_item(FUNC_BYTE, pick_other(cur_start));
			end
		end
		repeat (cur_run) send_item(FUNC_BYTE, cur_start);
		for (k = 0; k < body; k++) begin
			if (clean) begin
				b = pick_other(cur_end);
			end else begin
				case ($urandom_range(0, 15))
					0, 1: b = cur_end;
					2: b = cur_start;
					default: b = 8'($urandom_range(0, 255));
				endcase
			end
			send_item(FUNC_BYTE, b);
		end
		if (!clean && $urandom_range(0, 9) == 0) begin
			// Abort the frame before its end run.
			send_item(FUNC_RELEASE, 8'($urandom_range(0, 255)));
			return;
		end
		repeat (cur_run) send_item(FUNC_BYTE, cur_end);
		repeat ($urandom_range(0, 2)) send_item(FUNC_BYTE, 8'($urandom_range(0, 255)));
		send_item(FUNC_RELEASE, 8'($urandom_range(0, 255)));
	endtask

	// Result side: short random stalls, plus one long hold-off that backs up the input.
	initial begin
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!hold_done && results_seen >= 300) begin
				out_stall <= 1'b1;
				repeat (64) @(posedge clk);
				hold_done = 1'b1;
			end else if (idle_on && $urandom_range(0, 6) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
				@(posedge clk);
			end
		end
	end

	initial begin
		#3_000_000;
		$display("timeout waiting for results");
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		int ph;
		int goal;
		logic [7:0] s;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: start and end are both 0x00, run of three.
		send_item(FUNC_RELEASE, 8'hFF);
		repeat (3) send_item(FUNC_BYTE, 8'h00);
		send_item(FUNC_BYTE, 8'hFF);
		send_item(FUNC_BYTE, 8'hA5);
		repeat (3) send_item(FUNC_BYTE, 8'h00);
		// Locked: these are not captured.
		send_item(FUNC_BYTE, 8'h12);
		send_item(FUNC_BYTE, 8'h00);
		send_item(FUNC_RELEASE, 8'h00);
		// An empty body gives a frame too short to hold the check field.
		repeat (6) send_item(FUNC_BYTE, 8'h00);
		send_item(FUNC_RELEASE, 8'h5A);
		// A start run broken by another byte does not arm.
		repeat (2) send_item(FUNC_BYTE, 8'h00);
		send_item(FUNC_BYTE, 8'h5A);
		send_item(FUNC_RELEASE, 8'hFF);
		drain_results(4);

		for (ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: write_regs(8'h7E, 8'h7E, 8'h00);
				1: write_regs(8'h00, 8'hFF, 8'h08);
				2: write_regs(8'hFF, 8'h00, 8'hFF);
				default: begin
					s = 8'($urandom_range(0, 255));
					write_regs(s, ($urandom_range(0, 3) == 0) ? s : 8'($urandom_range(0, 255)),
						8'($urandom_range(0, 255)));
				end
			endcase
			if (ph == PHASES - 1)
				idle_on = 1'b0;
			goal = requests_sent + PHASE_ITEMS;
			// A frame of exactly the buffer depth wraps to a length of zero.
			if (ph == 1)
				send_frame(BUFFER_DEPTH - cur_run, 1'b1);
			if (ph == 3)
				send_frame(300, 1'b1);
			while (requests_sent < goal)
				send_frame($urandom_range(0, 12), 1'b0);
			drain_results((ph == PHASES - 1) ? 8 : 4);
		end

		$display("Ran %0d requests through %0d register settings;",
			requests_sent, PHASES + 1);
		$display("%0d frames completed, %0d too short.", frames_done, short_frames);
		$display("The input was held off for %0d cycles by a full result buffer.", stall_cycles);
		if (mismatch_count == 0 && pending_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
